FILE: hw/rtl/pad_pkg.sv
// Shared types and constants for the PWM angle decoder.
// Used by the top level, pad_div, pad_ring and the checker; depends on nothing.
package pad_pkg;

  localparam int unsigned TS_W              = 32;
  localparam int unsigned BT_W              = 4;
  localparam int unsigned ANGLE_W           = 16;
  localparam int unsigned HIGH_W            = 16;
  localparam int unsigned DATA_W            = 18;
  localparam int unsigned MUL_W             = 30;
  localparam int unsigned PROD_W            = 28;
  localparam int unsigned DEN_W             = 16;
  localparam int unsigned AVG_DEPTH_DEFAULT = 10;

  localparam int unsigned PREAMBLE_BITS     = 128;
  localparam int unsigned FULL_SCALE_TENTHS = 3600;
  localparam int unsigned DATA_STEPS        = 4095;
  localparam int unsigned ANGLE_MAX         = 32767;
  localparam int          ANGLE_MIN         = -112;
  localparam logic [BT_W-1:0] BIT_TIME_RESET = BT_W'(2);

  typedef enum logic [0:0] {
    OP_EDGE = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    CFG_BIT_TIME = 1'b0,
    CFG_AVG_EN   = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_ANGLE,
    ST_RING,
    ST_DIV_AVG,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic               push;
    logic [ANGLE_W-1:0] angle;
  } ring_req_t;

endpackage

FILE: hw/rtl/pwm_angle_decoder_with_average.sv
// Top level of the PWM angle decoder with moving average.
// Depends on pad_pkg, pad_div, pad_ring (and through it pad_ram).
//
// Usage:
//   Input words arrive on the s_axis channel. s_axis_tuser selects the kind:
//   an edge event (pin level in tdata[0], microsecond timestamp in
//   tdata[32:1]) or a read request (tdata ignored). Edge events update the
//   rise/fall time registers in the accept cycle and produce no output.
//   A read request yields one signed 16-bit angle in tenths of a degree on
//   m_axis.
//   A read runs through the serial divider for the angle scaling, and with
//   averaging also through a ring update and a reciprocal multiply by
//   1/AVERAGE_DEPTH. Throughput: one edge per cycle while idle; a new read
//   is taken only after the last has gone to the output register. The
//   sequencer holds s_axis_tready low while a read is in flight.
//   The result sits in an output register; the block takes further edges
//   while it waits there. If a second read finishes before the first result
//   is taken, hold it in the final state until the output register frees.
//   Reset: bit_time returns to 2, averaging is enabled, all times, the ring
//   (through per-entry valid bits), the sum and the position clear at once;
//   the block is ready in the first cycle after reset.
//   Configuration writes (cfg_index_i 0 = bit_time, 1 = average_enable) are
//   always accepted; issue them only while the block is idle.
module pwm_angle_decoder_with_average import pad_pkg::*; #(
  parameter int unsigned AVERAGE_DEPTH = AVG_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [39:0]        s_axis_tdata,   // [0] pin_level, [32:1] timestamp_us, zero pad
  input  logic [0:0]         s_axis_tuser,   // [0] operation
  // Output stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [ANGLE_W-1:0] m_axis_tdata,   // [15:0] angle_tenths
  // Configuration writes.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [BT_W-1:0]    cfg_data_i
);

  localparam int unsigned SUM_W = ANGLE_W + $clog2(AVERAGE_DEPTH);
  localparam logic signed [MUL_W-1:0] FULL_SCALE_S = MUL_W'(FULL_SCALE_TENTHS);
  // Reciprocal of the ring depth, exact for every sum magnitude below 2^SUM_W.
  localparam int unsigned AVG_SHIFT  = SUM_W + $clog2(AVERAGE_DEPTH);
  localparam int unsigned AVG_PROD_W = 2 * SUM_W + 1;
  localparam longint unsigned AVG_RECIP =
    ((64'd1 << AVG_SHIFT) + 64'(AVERAGE_DEPTH) - 64'd1) / 64'(AVERAGE_DEPTH);

  // Configuration registers.
  logic [BT_W-1:0] bit_time_q;
  logic            avg_en_q;

  // Edge time registers.
  logic [TS_W-1:0] pending_rise_q;
  logic [TS_W-1:0] latched_rise_q;
  logic [TS_W-1:0] latched_fall_q;

  // Sequencer and datapath registers.
  state_e                    state_q, state_d;
  logic signed [DATA_W-1:0]  data_q;
  logic [DEN_W-1:0]          den_q;
  logic                      neg_q;
  logic [SUM_W-1:0]          avg_mag_q;
  logic [ANGLE_W-1:0]        angle_q;
  logic [ANGLE_W-1:0]        out_q;
  logic                      out_valid_q;

  logic                      in_acc;
  logic                      out_free;
  logic                      out_load;
  logic [TS_W-1:0]           high_full;
  logic [HIGH_W-1:0]         high_sat;
  logic [BT_W-1:0]           bt_eff;
  logic signed [DATA_W-1:0]  data_d;
  logic [DEN_W-1:0]          den_d;
  logic signed [MUL_W-1:0]   prod;
  logic [MUL_W-1:0]          prod_mag;
  logic signed [SUM_W-1:0]   sum_new;
  logic [SUM_W-1:0]          sum_mag;
  logic [AVG_PROD_W-1:0]     avg_prod;
  logic [ANGLE_W-1:0]        avg_quot;
  logic [ANGLE_W-1:0]        angle_raw;
  logic [ANGLE_W-1:0]        angle_avg;

  div_req_t          div_req;
  logic              div_done;
  logic [PROD_W-1:0] div_quot;
  ring_req_t         ring_req;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign out_free    = !out_valid_q || m_axis_tready;

  // High time, preamble removal and divisor, formed from the latched pair.
  assign high_full = latched_fall_q - latched_rise_q;
  assign high_sat  = (|high_full[TS_W-1:HIGH_W]) ? '1 : high_full[HIGH_W-1:0];
  assign bt_eff    = (bit_time_q == '0) ? BT_W'(1) : bit_time_q;
  assign data_d    = $signed({{(DATA_W - HIGH_W){1'b0}}, high_sat})
                   - $signed(DATA_W'(bt_eff) * DATA_W'(PREAMBLE_BITS));
  assign den_d     = DEN_W'(bt_eff) * DEN_W'(DATA_STEPS);

  assign prod      = MUL_W'(data_q) * FULL_SCALE_S;
  assign prod_mag  = prod[MUL_W-1] ? MUL_W'(-prod) : MUL_W'(prod);
  assign sum_mag   = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

  // Average: multiply the held sum magnitude by the scaled reciprocal.
  assign avg_prod  = AVG_PROD_W'(avg_mag_q) * AVG_PROD_W'(AVG_RECIP);
  assign avg_quot  = avg_prod[AVG_SHIFT +: ANGLE_W];

  // Angle: negate negative quotients, saturate large positive ones.
  always_comb begin
    if (neg_q) begin
      angle_raw = ANGLE_W'(-div_quot[ANGLE_W-1:0]);
    end else if (div_quot > PROD_W'(ANGLE_MAX)) begin
      angle_raw = ANGLE_W'(ANGLE_MAX);
    end else begin
      angle_raw = div_quot[ANGLE_W-1:0];
    end
  end

  assign angle_avg = neg_q ? ANGLE_W'(-avg_quot) : avg_quot;

  // Sequencer: next state and control.
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    div_req       = '0;
    ring_req      = '0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && (s_axis_tuser == OP_READ)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        div_req.start = 1'b1;
        div_req.num   = prod_mag[PROD_W-1:0];
        div_req.den   = den_q;
        state_d       = ST_DIV_ANGLE;
      end
      ST_DIV_ANGLE: begin
        if (div_done) begin
          state_d = avg_en_q ? ST_RING : ST_OUT;
        end
      end
      ST_RING: begin
        ring_req.push  = 1'b1;
        ring_req.angle = angle_q;
        state_d        = ST_DIV_AVG;
      end
      ST_DIV_AVG: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_time_q <= BIT_TIME_RESET;
      avg_en_q   <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BIT_TIME: bit_time_q <= cfg_data_i;
        CFG_AVG_EN:   avg_en_q   <= cfg_data_i[0];
        default:      bit_time_q <= bit_time_q;
      endcase
    end
  end

  // Edge events: record a rise, latch the pair on a fall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_rise_q <= '0;
      latched_rise_q <= '0;
      latched_fall_q <= '0;
    end else if (in_acc && (s_axis_tuser == OP_EDGE)) begin
      if (s_axis_tdata[0]) begin
        pending_rise_q <= s_axis_tdata[TS_W:1];
      end else begin
        latched_fall_q <= s_axis_tdata[TS_W:1];
        latched_rise_q <= pending_rise_q;
      end
    end
  end

  // Datapath registers along the read sequence.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      data_q <= data_d;
      den_q  <= den_d;
    end
    if (state_q == ST_MUL) begin
      neg_q <= prod[MUL_W-1];
    end
    if (state_q == ST_RING) begin
      neg_q     <= sum_new[SUM_W-1];
      avg_mag_q <= sum_mag;
    end
    if ((state_q == ST_DIV_ANGLE) && div_done) begin
      angle_q <= angle_raw;
    end
    if (state_q == ST_DIV_AVG) begin
      angle_q <= angle_avg;
    end
    if (out_load) begin
      out_q <= angle_q;
    end
  end

  // Output register: set on load, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  pad_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quot_o(div_quot)
  );

  pad_ring #(
    .AVERAGE_DEPTH(AVERAGE_DEPTH)
  ) u_ring (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ring_req),
    .sum_o (sum_new)
  );

endmodule

FILE: hw/rtl/pad_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; instanced by the reading ring.
module pad_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 10,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/pad_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on pad_pkg for operand widths and the request struct.
module pad_div import pad_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output logic              done_o,
  output logic [PROD_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] diff;
  logic           fits;

  assign rem_sh = {rem_q, num_q[PROD_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign fits   = ~diff[DEN_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(PROD_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != CNT_W'(1));
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: shift the dividend out and the quotient bits in.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[PROD_W-2:0], fits};
      rem_q <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

FILE: hw/rtl/pad_ring.sv
// Moving-average ring: reading RAM, per-entry valid bits, write position
// and running sum. Depends on pad_pkg and pad_ram.
module pad_ring import pad_pkg::*; #(
  parameter int unsigned AVERAGE_DEPTH = AVG_DEPTH_DEFAULT,
  localparam int unsigned SUM_W = ANGLE_W + $clog2(AVERAGE_DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ring_req_t               req_i,
  output logic signed [SUM_W-1:0] sum_o
);

  localparam int unsigned IDX_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(AVERAGE_DEPTH - 1);

  logic [IDX_W-1:0]         pos_q, pos_d;
  logic [AVERAGE_DEPTH-1:0] valid_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [ANGLE_W-1:0]       rd_data;
  logic signed [ANGLE_W-1:0] old_val;

  // Entry never written reads as zero.
  assign old_val = valid_q[pos_q] ? $signed(rd_data) : '0;
  assign sum_o   = sum_q - SUM_W'(old_val) + SUM_W'($signed(req_i.angle));
  assign pos_d   = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= '0;
      sum_q   <= '0;
    end else if (req_i.push) begin
      valid_q[pos_q] <= 1'b1;
      pos_q          <= pos_d;
      sum_q          <= sum_o;
    end
  end

  pad_ram #(
    .WIDTH(ANGLE_W),
    .DEPTH(AVERAGE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.push),
    .waddr_i(pos_q),
    .wdata_i(req_i.angle),
    .raddr_i(pos_q),
    .rdata_o(rd_data)
  );

endmodule

FILE: hw/rtl/pad_checker.sv
// Port-level checker for the PWM angle decoder, bound to the top level.
// Depends on pad_pkg for field widths and operation codes.
module pad_checker import pad_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [0:0]         s_axis_tuser,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [ANGLE_W-1:0] m_axis_tdata
);

  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN_S = ANGLE_W'(ANGLE_MIN);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Only a read request takes the block out of its ready state.
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid && (s_axis_tuser == OP_READ)))
    else $error("input ready dropped without a read request");

  // An edge event completes in its accept cycle.
  a_edge_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_EDGE) |=> s_axis_tready)
    else $error("edge event stalled the input");

  // Angles never fall below the most negative preamble value.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata) >= ANGLE_MIN_S)
    else $error("angle below range");

endmodule

bind pwm_angle_decoder_with_average pad_checker u_pad_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
